// ===== rtl/ttm_pkg.sv =====
// Shared types and constants of the tap tempo median BPM unit.
// No dependencies; every other file imports this package.
package ttm_pkg;

   typedef struct packed {
      logic [31:0] tap_time_ms;
      logic        from_beat_key;
      logic        beat_key_down;
   } req_item_type;

   typedef struct packed {
      logic [15:0] median_interval_ms;
      logic [23:0] bpm_q8;
      logic        interval_accepted;
   } rsp_item_type;

   // window cell controls, driven by the sequencer in the top level
   typedef struct packed {
      logic shift;   // take the neighbour's entry (newest cell: the new interval)
      logic load;    // copy own entry into the circulating slot, clear counts
      logic rotate;  // compare against circulating entry, pass it on
   } cell_ctrl_type;

   localparam logic [0:0]  REG_MIN_INTERVAL = 1'b0;
   localparam logic [0:0]  REG_MAX_INTERVAL = 1'b1;

   localparam logic [15:0] MIN_INTERVAL_RESET = 16'd100;
   localparam logic [15:0] MAX_INTERVAL_RESET = 16'd5000;

   // 60 s * 1000 ms * 256 (Q.8)
   localparam logic [23:0] BPM_Q8_NUM = 24'd15360000;
   localparam int          DIV_STEPS  = 24;

   localparam int          RESET_LIST_LEN = 7;
   localparam logic [15:0] RESET_FILL     = 16'd1000;
   localparam logic [RESET_LIST_LEN-1:0][15:0] RESET_LIST = {
      16'd1000, 16'd1000, 16'd1400, 16'd1000, 16'd1100, 16'd1200, 16'd900
   };

   // reset content of window entry idx (0 = oldest) for a window of wl entries
   function automatic logic [15:0] reset_entry(input int idx, input int wl);
      int k;
      k = idx + RESET_LIST_LEN - wl;
      if (k >= 0 && k < RESET_LIST_LEN) begin
         return RESET_LIST[k];
      end
      return RESET_FILL;
   endfunction

endpackage

// ===== rtl/ttm_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on ttm_pkg for the payload types.
interface ttm_req_if;
   import ttm_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ttm_rsp_if;
   import ttm_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ttm_cell.sv =====
// One window cell: holds an interval, shifts towards the oldest end, and
// ranks its entry against the others as they circulate round the ring.
// Depends on ttm_pkg.
module ttm_cell #(
   parameter int          WINDOW_LEN  = 7,
   parameter logic [15:0] RESET_VALUE = 16'd1000
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ttm_pkg::cell_ctrl_type ctrl_i,
   input  logic [15:0]            shift_in_i,
   input  logic [15:0]            circ_in_i,
   output logic [15:0]            value_o,
   output logic [15:0]            circ_o,
   output logic                   qualifies_o
);
   import ttm_pkg::*;

   localparam int CW         = $clog2(WINDOW_LEN + 1);
   localparam int MEDIAN_POS = WINDOW_LEN / 2;

   logic [15:0]   value_ff, value_in;
   logic [15:0]   circ_ff, circ_in;
   logic [CW-1:0] gt_ff, gt_in;
   logic [CW-1:0] ge_ff, ge_in;

   always_comb begin
      value_in = ctrl_i.shift ? shift_in_i : value_ff;
      circ_in  = circ_ff;
      gt_in    = gt_ff;
      ge_in    = ge_ff;
      if (ctrl_i.load) begin
         circ_in = value_ff;
         gt_in   = '0;
         ge_in   = '0;
      end else if (ctrl_i.rotate) begin
         circ_in = circ_in_i;
         gt_in   = gt_ff + CW'(circ_ff > value_ff);
         ge_in   = ge_ff + CW'(circ_ff >= value_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= RESET_VALUE;
      end else begin
         value_ff <= value_in;
      end
      circ_ff <= circ_in;
      gt_ff   <= gt_in;
      ge_ff   <= ge_in;
   end

   // descending order: entry sits at MEDIAN_POS when at most that many are
   // strictly larger and more than that many are larger or equal
   assign qualifies_o = (gt_ff <= CW'(MEDIAN_POS)) && (ge_ff > CW'(MEDIAN_POS));
   assign value_o     = value_ff;
   assign circ_o      = circ_ff;

endmodule

// ===== rtl/ttm_div.sv =====
// Restoring divider, one quotient bit per cycle, 24-bit dividend by 16-bit
// divisor. A zero divisor gives an all-ones quotient. Depends on ttm_pkg.
module ttm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start_i,
   input  logic [23:0] dividend_i,
   input  logic [15:0] divisor_i,
   output logic        done_o,
   output logic [23:0] quotient_o
);
   import ttm_pkg::*;

   localparam int SW = $clog2(DIV_STEPS);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [SW-1:0] step_ff, step_in;
   logic [15:0]   rem_ff, rem_in;
   logic [23:0]   quot_ff, quot_in;
   logic [15:0]   dvs_ff, dvs_in;
   logic [16:0]   trial;
   logic          fits;

   always_comb begin
      trial   = {rem_ff, quot_ff[23]};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      if (start_i) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quot_in = dividend_i;
         dvs_in  = divisor_i;
      end else if (busy_ff) begin
         rem_in  = fits ? 16'(trial - {1'b0, dvs_ff}) : trial[15:0];
         quot_in = {quot_ff[22:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == SW'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

   assign done_o     = done_ff;
   assign quotient_o = quot_ff;

endmodule

// ===== rtl/tap_tempo_median_bpm_unit.sv =====
// Tap tempo estimator: sliding window of beat intervals, median, BPM in Q.8.
// From request transfer to response valid: one load, WINDOW_LEN ranking
// passes round the cell ring, one select, 24 divider steps, the divider done
// strobe and one output load. One item at a time: the next request is taken
// once the response sits in the output register. Sync reset restores the
// control state, the limits, the last tap time and the window contents.
module tap_tempo_median_bpm_unit #(
   parameter int WINDOW_LEN = 7
) (
   input  logic        clock,
   input  logic        reset,
   ttm_req_if.sink     req_chan,
   ttm_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ttm_pkg::*;

   localparam int RCW = $clog2(WINDOW_LEN);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_RANK   = 3'd2;
   localparam logic [2:0] ST_SELECT = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_OUT    = 3'd5;

   logic [2:0]     state_ff, state_in;
   logic [RCW-1:0] rank_ff, rank_in;
   logic [15:0]    min_ff, min_in;
   logic [15:0]    max_ff, max_in;
   logic [31:0]    last_tap_ff, last_tap_in;
   logic           acc_ff, acc_in;
   logic [15:0]    med_ff, med_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_item_type   rsp_data_ff, rsp_data_in;

   logic          req_fire;
   logic          cfg_write;
   logic [31:0]   diff;
   logic          in_range;
   logic          take;
   logic          out_free;
   logic [15:0]   sel_med;
   logic          div_start;
   logic          div_done;
   logic [23:0]   quotient;
   cell_ctrl_type cell_ctrl;

   logic [WINDOW_LEN-1:0][15:0] window_values;
   logic [WINDOW_LEN-1:0][15:0] circ_values;
   logic [WINDOW_LEN-1:0]       qualify;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign cfg_write = psel && penable && pwrite && pready;
   assign diff      = req_chan.data.tap_time_ms - last_tap_ff;
   assign in_range  = !diff[31] && (diff > {16'h0, min_ff}) && (diff < {16'h0, max_ff});
   assign take      = req_fire && req_chan.data.beat_key_down
                      && req_chan.data.from_beat_key && in_range;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign div_start = (state_ff == ST_SELECT);

   assign cell_ctrl.shift  = take;
   assign cell_ctrl.load   = (state_ff == ST_LOAD);
   assign cell_ctrl.rotate = (state_ff == ST_RANK);

   // window ring: entry 0 is the oldest, the new interval enters at the top
   for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
      localparam int NEXT = (i + 1) % WINDOW_LEN;
      logic [15:0] shift_src;
      if (i == WINDOW_LEN - 1) begin : g_top
         assign shift_src = diff[15:0];
      end else begin : g_mid
         assign shift_src = window_values[i+1];
      end
      ttm_cell #(
         .WINDOW_LEN  (WINDOW_LEN),
         .RESET_VALUE (reset_entry(i, WINDOW_LEN))
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl_i      (cell_ctrl),
         .shift_in_i  (shift_src),
         .circ_in_i   (circ_values[NEXT]),
         .value_o     (window_values[i]),
         .circ_o      (circ_values[i]),
         .qualifies_o (qualify[i])
      );
   end

   // all qualifying cells hold the same value; lowest index wins
   always_comb begin
      sel_med = '0;
      for (int i = WINDOW_LEN - 1; i >= 0; i--) begin
         if (qualify[i]) begin
            sel_med = window_values[i];
         end
      end
   end

   ttm_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start_i    (div_start),
      .dividend_i (BPM_Q8_NUM + 24'(sel_med[15:1])),
      .divisor_i  (sel_med),
      .done_o     (div_done),
      .quotient_o (quotient)
   );

   always_comb begin
      state_in     = state_ff;
      rank_in      = rank_ff;
      last_tap_in  = last_tap_ff;
      acc_in       = acc_ff;
      med_in       = med_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      min_in       = min_ff;
      max_in       = max_ff;

      if (cfg_write) begin
         unique case (paddr[2])
            REG_MIN_INTERVAL: min_in = pwdata[15:0];
            REG_MAX_INTERVAL: max_in = pwdata[15:0];
            default:          min_in = min_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_chan.data.beat_key_down) begin
               acc_in   = take;
               state_in = ST_LOAD;
               if (req_chan.data.from_beat_key) begin
                  last_tap_in = req_chan.data.tap_time_ms;
               end
            end
         end
         ST_LOAD: begin
            rank_in  = '0;
            state_in = ST_RANK;
         end
         ST_RANK: begin
            rank_in = rank_ff + 1'b1;
            if (rank_ff == RCW'(WINDOW_LEN - 1)) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            med_in   = sel_med;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.median_interval_ms = med_ff;
               rsp_data_in.bpm_q8             = quotient;
               rsp_data_in.interval_accepted  = acc_ff;
               state_in                       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rank_ff      <= '0;
         last_tap_ff  <= '0;
         min_ff       <= MIN_INTERVAL_RESET;
         max_ff       <= MAX_INTERVAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rank_ff      <= rank_in;
         last_tap_ff  <= last_tap_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff      <= acc_in;
      med_ff      <= med_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      unique case (paddr[2])
         REG_MIN_INTERVAL: prdata = {16'h0, min_ff};
         REG_MAX_INTERVAL: prdata = {16'h0, max_ff};
         default:          prdata = '0;
      endcase
   end

   assign pready         = 1'b1;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // the ranking pass must always find the median
   a_median_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SELECT) |-> (|qualify))
      else $error("no window cell qualified as median");

   // window only moves on a request transfer
   a_window_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> $stable(window_values))
      else $error("window changed while an item was in progress");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("response raised outside the output state");

endmodule

// ===== dv/tap_tempo_median_bpm_unit_checker.sv =====
// Scoreboard for the tap tempo median BPM unit: follows limit writes and request
// transfers, predicts each response and compares it field by field.
// Depends on ttm_pkg for the payload types and register codes.
module tap_tempo_median_bpm_unit_checker #(
   parameter int WINDOW_LEN = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  ttm_pkg::req_item_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ttm_pkg::rsp_item_type rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output int                    mismatch_count,
   output int                    outstanding,
   output int                    responses_checked,
   output int                    intervals_taken
);
   import ttm_pkg::*;

   localparam logic [31:0] TEMPO_Q8_SCALE = 32'd15360000;
   localparam int          POWER_UP_LEN   = 7;
   localparam logic [15:0] POWER_UP_WINDOW [POWER_UP_LEN] = '{
      16'd900, 16'd1200, 16'd1100, 16'd1000, 16'd1400, 16'd1000, 16'd1000
   };

   logic [15:0]  beat_window [WINDOW_LEN];   // index 0 is the oldest interval
   logic [31:0]  last_tap;
   logic [15:0]  min_gap;
   logic [15:0]  max_gap;
   rsp_item_type tempo_q [$];
   int           fails;
   int           results;
   int           taken;

   // updates the window and last tap; returns 0 when the key is up (no response)
   function automatic bit predict_tempo(input req_item_type ev, output rsp_item_type res);
      logic [31:0] gap;
      logic [15:0] ranked [WINDOW_LEN];
      logic [15:0] pick;
      logic [31:0] quot;
      int          j;
      res = '0;
      if (!ev.beat_key_down) begin
         return 1'b0;
      end
      if (ev.from_beat_key) begin
         gap = ev.tap_time_ms - last_tap;
         // signed reading: a backward step, or one of 2**31 or more, is never taken
         if (!gap[31] && gap > 32'(min_gap) && gap < 32'(max_gap)) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
               beat_window[i] = beat_window[i + 1];
            end
            beat_window[WINDOW_LEN - 1] = gap[15:0];
            res.interval_accepted = 1'b1;
         end
         last_tap = ev.tap_time_ms;
      end
      // descending insertion sort, median taken from the middle slot
      ranked = beat_window;
      for (int i = 1; i < WINDOW_LEN; i++) begin
         pick = ranked[i];
         j = i - 1;
         while (j >= 0 && ranked[j] < pick) begin
            ranked[j + 1] = ranked[j];
            j--;
         end
         ranked[j + 1] = pick;
      end
      res.median_interval_ms = ranked[WINDOW_LEN / 2];
      if (res.median_interval_ms == 16'd0) begin
         res.bpm_q8 = '1;
      end else begin
         // round to nearest; the largest quotient still fits 24 bits
         quot = (TEMPO_Q8_SCALE + 32'(res.median_interval_ms >> 1))
                / 32'(res.median_interval_ms);
         res.bpm_q8 = quot[23:0];
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      rsp_item_type want;
      rsp_item_type fresh;
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            if (i + POWER_UP_LEN - WINDOW_LEN >= 0) begin
               beat_window[i] = POWER_UP_WINDOW[i + POWER_UP_LEN - WINDOW_LEN];
            end else begin
               beat_window[i] = 16'd1000;
            end
         end
         last_tap = '0;
         min_gap  = MIN_INTERVAL_RESET;
         max_gap  = MAX_INTERVAL_RESET;
         tempo_q.delete();
         fails   = 0;
         results = 0;
         taken   = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results++;
            if (tempo_q.size() == 0) begin
               fails++;
               if (fails <= 10) begin
                  $display("%0t: unexpected response median %0d bpm_q8 %0d taken %0b",
                           $realtime, rsp_data.median_interval_ms, rsp_data.bpm_q8,
                           rsp_data.interval_accepted);
               end
            end else begin
               want = tempo_q.pop_front();
               if (rsp_data.median_interval_ms !== want.median_interval_ms
                   || rsp_data.bpm_q8 !== want.bpm_q8
                   || rsp_data.interval_accepted !== want.interval_accepted) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("%0t: response %0d expected median %0d bpm_q8 %0d taken %0b",
                              $realtime, results, want.median_interval_ms, want.bpm_q8,
                              want.interval_accepted);
                     $display("%0t: response %0d actual   median %0d bpm_q8 %0d taken %0b",
                              $realtime, results, rsp_data.median_interval_ms,
                              rsp_data.bpm_q8, rsp_data.interval_accepted);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            if (predict_tempo(req_data, fresh)) begin
               tempo_q.push_back(fresh);
               if (fresh.interval_accepted) begin
                  taken++;
               end
            end
         end
         // the checker assumes limit writes land only while the unit is idle; the unit itself does not enforce this
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2:2] == REG_MIN_INTERVAL) begin
               min_gap = csr_pwdata[15:0];
            end else if (csr_paddr[2:2] == REG_MAX_INTERVAL) begin
               max_gap = csr_pwdata[15:0];
            end
         end
      end
      mismatch_count    <= fails;
      outstanding       <= tempo_q.size();
      responses_checked <= results;
      intervals_taken   <= taken;
   end

endmodule

// ===== dv/tap_tempo_median_bpm_unit_test.sv =====
// Testbench top for the tap tempo median BPM unit: clock, reset, tap stimulus,
// limit writes and the verdict. Depends on ttm_pkg, ttm_if, the unit and the checker.
module tap_tempo_median_bpm_unit_test;
   import ttm_pkg::*;

   localparam int ITEM_TARGET   = 1250;
   localparam int STALL_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 500;
   localparam int PHASES        = 8;
   localparam int CALM_PHASE    = 5;
   localparam logic [15:0] LOWER_LIMITS [PHASES] = '{
      16'd100, 16'd0, 16'd0, 16'd65535, 16'd999, 16'd50, 16'd1000, 16'd100
   };
   localparam logic [15:0] UPPER_LIMITS [PHASES] = '{
      16'd5000, 16'd65535, 16'd1, 16'd65535, 16'd1001, 16'd300, 16'd1001, 16'd5000
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   logic        calm;
   logic [31:0] stamp;
   logic [15:0] lower;
   logic [15:0] upper;
   int          sent = 0;
   int          key_up_sent = 0;
   int          idle_cycles = 0;
   int          delivered = 0;
   int          hold_left = 0;
   bit          held = 1'b0;
   int          mismatch_count;
   int          outstanding;
   int          responses_checked;
   int          intervals_taken;

   ttm_req_if req_if ();
   ttm_rsp_if rsp_if ();

   tap_tempo_median_bpm_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   tap_tempo_median_bpm_unit_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_if.valid),
      .req_ready         (req_if.ready),
      .req_data          (req_if.data),
      .rsp_valid         (rsp_if.valid),
      .rsp_ready         (rsp_if.ready),
      .rsp_data          (rsp_if.data),
      .csr_psel          (psel),
      .csr_penable       (penable),
      .csr_pwrite        (pwrite),
      .csr_pready        (pready),
      .csr_paddr         (paddr),
      .csr_pwdata        (pwdata),
      .mismatch_count    (mismatch_count),
      .outstanding       (outstanding),
      .responses_checked (responses_checked),
      .intervals_taken   (intervals_taken)
   );

   always #6 clock = ~clock;

   // response side: random stalls, one long hold once 150 responses are delivered
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            delivered <= delivered + 1;
         end
         if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
         end else if (!held && delivered >= 150) begin
            held         <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= calm || ($urandom_range(0, 99) >= 7);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input req_item_type ev);
      if (!calm && $urandom_range(0, 99) < 7) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 45)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= ev;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (ev.beat_key_down && ev.from_beat_key) begin
         stamp = ev.tap_time_ms;
      end
      sent++;
      if (!ev.beat_key_down) begin
         key_up_sent++;
      end
   endtask

   task automatic send_tap(input logic [31:0] t, input logic beat, input logic down);
      req_item_type ev;
      ev.tap_time_ms   = t;
      ev.from_beat_key = beat;
      ev.beat_key_down = down;
      send_item(ev);
   endtask

   // leaves psel up so that a following write goes straight into its setup cycle
   task automatic write_limit(input logic [0:0] reg_sel, input logic [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly well-formed beat taps spaced against the current limits
   function automatic req_item_type next_item();
      req_item_type ev;
      int           pick;
      int           lo;
      int           hi;
      logic [31:0]  gap;
      lo = int'(lower);
      hi = int'(upper);
      pick = $urandom_range(0, 99);
      ev.tap_time_ms   = $urandom;
      ev.from_beat_key = 1'($urandom_range(0, 1));
      ev.beat_key_down = 1'b1;
      if (pick < 70) begin
         ev.from_beat_key = 1'b1;
         if ($urandom_range(0, 99) < 80 && hi > lo + 1) begin
            gap = 32'($urandom_range(lo + 1, hi - 1));
         end else begin
            case ($urandom_range(0, 5))
               0:       gap = 32'(lo);
               1:       gap = 32'(lo + 1);
               2:       gap = 32'(hi - 1);
               3:       gap = 32'(hi);
               4:       gap = 32'($urandom_range(0, 200000));
               default: gap = 32'd0 - 32'($urandom_range(1, 1000));
            endcase
         end
         ev.tap_time_ms = stamp + gap;
      end else if (pick < 80) begin
         ev.from_beat_key = 1'b0;
      end else if (pick < 90) begin
         ev.beat_key_down = 1'b0;
      end
      return ev;
   endfunction

   initial begin
      req_item_type ev;
      int           n;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      calm         = 1'b0;
      stamp        = '0;
      lower        = MIN_INTERVAL_RESET;
      upper        = MAX_INTERVAL_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            settle();
            lower = LOWER_LIMITS[ph];
            upper = UPPER_LIMITS[ph];
            write_limit(REG_MIN_INTERVAL, lower);
            write_limit(REG_MAX_INTERVAL, upper);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
         end
         calm <= (ph == CALM_PHASE);
         if (ph == 0) begin
            send_tap(32'd1000, 1'b1, 1'b0);        // key up: ignored
            send_tap(32'hFFFF_FFFF, 1'b0, 1'b1);   // other key: current median
            send_tap(32'd500, 1'b1, 1'b1);
            send_tap(32'd600, 1'b1, 1'b1);         // equals minimum
            send_tap(32'd701, 1'b1, 1'b1);
            send_tap(32'd5701, 1'b1, 1'b1);        // equals maximum
            send_tap(32'd10700, 1'b1, 1'b1);
            send_tap(32'd10000, 1'b1, 1'b1);       // backwards
            send_tap(32'hFFFF_FF00, 1'b1, 1'b1);   // sign bit set
            send_tap(32'h0000_0010, 1'b1, 1'b1);   // wraps through zero
            send_tap(32'h8000_0010, 1'b1, 1'b1);   // most negative step
            send_tap(32'h0000_000F, 1'b1, 1'b1);   // largest positive step
            send_tap(32'd0, 1'b0, 1'b0);
         end else if (ph == 1) begin
            // shortest then longest intervals take over the median
            repeat (4) send_tap(stamp + 32'd1, 1'b1, 1'b1);
            repeat (4) send_tap(stamp + 32'd65534, 1'b1, 1'b1);
         end
         n = 0;
         while (n < ITEM_TARGET / PHASES) begin
            ev = next_item();
            send_item(ev);
            n++;
         end
      end

      settle();
      $display("Covered %0d requests (%0d with the beat key up) across %0d limit settings,",
               sent, key_up_sent, PHASES);
      $display("%0d responses checked, %0d intervals entered the window",
               responses_checked, intervals_taken);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== tap_tempo_median_bpm_unit.f =====
rtl/ttm_pkg.sv
rtl/ttm_if.sv
rtl/ttm_cell.sv
rtl/ttm_div.sv
rtl/tap_tempo_median_bpm_unit.sv
dv/tap_tempo_median_bpm_unit_checker.sv
dv/tap_tempo_median_bpm_unit_test.sv
